// File: hw/rtl/akx_pkg.sv
`default_nettype none

package akx_pkg;

    localparam int MAX_KEY_WORDS = 8;
    localparam int WORD_BITS     = 32;
    localparam int CELLS         = 4;     // words per round key
    localparam int MAX_ROUNDS    = 14;

    localparam logic CFG_KEY_WORDS   = 1'b0;
    localparam logic CFG_ROUND_COUNT = 1'b1;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic [63:0] key_part0;
        logic [63:0] key_part1;
        logic [63:0] key_part2;
        logic [63:0] key_part3;
    } akx_in_t;

    typedef struct packed {
        logic [63:0] round_key_high;
        logic [63:0] round_key_low;
        logic [3:0]  round_index;
        logic        last_round;
    } akx_out_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic       advance;
        logic       use_key;
        logic [2:0] pos;
        logic       long_key;
        logic [7:0] rcon;
    } akx_cell_ctl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic word_t sub_word(input word_t w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/akx_cell.sv
`default_nettype none

module akx_cell
    import akx_pkg::*;
(
    input  wire logic          aclk,
    input  wire akx_cell_ctl_t ctl,
    input  wire word_t         key_word,
    input  wire word_t         prev_word,   // word i-1, from the left neighbour
    input  wire word_t         back_word,   // word i-Nk, from the window
    output word_t              new_word,
    output logic               rcon_hit,
    output word_t              upper_reg,
    output word_t              lower_reg
);

    word_t rot;
    word_t sb_in;
    word_t sb_out;
    word_t tmp;

    always_comb begin
        rot    = {prev_word[23:0], prev_word[31:24]};
        sb_in  = (ctl.pos == 3'd0) ? rot : prev_word;
        sb_out = sub_word(sb_in);
        if (ctl.pos == 3'd0) begin
            tmp = sb_out ^ {ctl.rcon, 24'h0};
        end else if (ctl.long_key && ctl.pos == 3'd4) begin
            tmp = sb_out;
        end else begin
            tmp = prev_word;
        end
        new_word = ctl.use_key ? key_word : (tmp ^ back_word);
        rcon_hit = (ctl.pos == 3'd0) && !ctl.use_key;
    end

    // lower slot holds word i-4, upper slot word i
    always_ff @(posedge aclk) begin
        if (ctl.advance) begin
            lower_reg <= upper_reg;
            upper_reg <= new_word;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/aes_key_expansion_unit.sv
// AES key schedule for 4 to 8 word keys (AES-128/192/256).
// Input channel s_*: one master key per transaction, s_data.key_part0..3,
// byte 0 in the top bits of key_part0. s_ready is high while no key is
// being expanded.
// Result channel m_*: one 128-bit round key per transaction, round 0 up to
// round_count clamped to 1..14, last_round set on the final one.
// Configuration: cfg_we/cfg_index/cfg_wdata, index 0 key_words, index 1
// round_count; write only while idle.
// A row of four word cells produces the four words of one round key per
// cycle unless the result channel stalls; the words ripple through the
// cells, with the S-box in each cell. After a key is accepted its round
// keys follow one per cycle when the receiver does not stall; no new key
// is taken until the last round key of the run has been produced.
// The last round key sits in the output register while the next key is taken.
// While m_valid is high and m_ready low the cells hold and nothing is lost.
// Reset (aresetn low, synchronous) drops any run in progress and loads
// key_words = 4, round_count = 10.
`default_nettype none

module aes_key_expansion_unit
    import akx_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    cfg_we,
    input  wire logic    cfg_index,
    input  wire logic [3:0] cfg_wdata,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire akx_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output akx_out_t     m_data
);

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        gf_double = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    logic [3:0] key_words_reg;
    logic [3:0] round_count_reg;
    logic       busy_reg;
    logic       m_valid_reg;
    logic [3:0] grp_reg;
    logic [2:0] pos_base_reg;
    logic [7:0] rcon_reg;
    logic [3:0] idx_out_reg;
    logic       last_out_reg;
    word_t      key_reg [2*CELLS];

    logic [3:0] nk;
    logic [3:0] nr;
    logic       accept;
    logic       advance;
    logic       any_hit;
    logic [3:0] pos_step;

    akx_cell_ctl_t ctl      [CELLS];
    word_t         new_w    [CELLS];
    word_t         prev_w   [CELLS];
    word_t         back_w   [CELLS];
    word_t         key_w    [CELLS];
    word_t         upper_w  [CELLS];
    word_t         lower_w  [CELLS];
    logic          hit      [CELLS];
    word_t         window   [2*CELLS];

    always_comb begin
        nk = key_words_reg;
        if (key_words_reg < 4'd4) begin
            nk = 4'd4;
        end else if (key_words_reg > 4'(MAX_KEY_WORDS)) begin
            nk = 4'(MAX_KEY_WORDS);
        end
        nr = round_count_reg;
        if (round_count_reg == 4'd0) begin
            nr = 4'd1;
        end else if (round_count_reg > 4'(MAX_ROUNDS)) begin
            nr = 4'(MAX_ROUNDS);
        end
    end

    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;
    assign advance = busy_reg && (!m_valid_reg || m_ready);
    assign any_hit = hit[0] || hit[1] || hit[2] || hit[3];

    always_comb begin
        pos_step = {1'b0, pos_base_reg} + 4'd4;
        if (pos_step >= nk) begin
            pos_step = pos_step - nk;
        end
    end

    for (genvar j = 0; j < CELLS; j++) begin : g_cell
        logic [5:0] word_idx;
        logic [3:0] pos_sum;
        logic [3:0] back_sel;

        assign word_idx = {grp_reg, 2'(j)};
        assign back_sel = 4'(2*CELLS + j) - nk;
        assign window[j]         = lower_w[j];
        assign window[j + CELLS] = upper_w[j];

        always_comb begin
            pos_sum = {1'b0, pos_base_reg} + 4'(j);
            if (pos_sum >= nk) begin
                pos_sum = pos_sum - nk;
            end
            ctl[j].advance  = advance;
            ctl[j].use_key  = word_idx < {2'b00, nk};
            ctl[j].pos      = pos_sum[2:0];
            ctl[j].long_key = nk > 4'd6;
            ctl[j].rcon     = rcon_reg;
        end

        assign key_w[j]  = (grp_reg == 4'd0) ? key_reg[j] : key_reg[j + CELLS];
        assign back_w[j] = window[back_sel[2:0]];

        if (j == 0) begin : g_head
            assign prev_w[j] = upper_w[CELLS-1];
        end else begin : g_body
            assign prev_w[j] = new_w[j-1];
        end

        akx_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl[j]),
            .key_word  (key_w[j]),
            .prev_word (prev_w[j]),
            .back_word (back_w[j]),
            .new_word  (new_w[j]),
            .rcon_hit  (hit[j]),
            .upper_reg (upper_w[j]),
            .lower_reg (lower_w[j])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_words_reg   <= 4'd4;
            round_count_reg <= 4'd10;
            busy_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
            grp_reg         <= '0;
            pos_base_reg    <= '0;
            rcon_reg        <= 8'h01;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_KEY_WORDS) begin
                    key_words_reg <= cfg_wdata;
                end else begin
                    round_count_reg <= cfg_wdata;
                end
            end
            if (accept) begin
                busy_reg     <= 1'b1;
                grp_reg      <= '0;
                pos_base_reg <= '0;
                rcon_reg     <= 8'h01;
            end
            if (advance) begin
                m_valid_reg  <= 1'b1;
                grp_reg      <= grp_reg + 4'd1;
                pos_base_reg <= pos_step[2:0];
                if (any_hit) begin
                    rcon_reg <= gf_double(rcon_reg);
                end
                if (grp_reg == nr) begin
                    busy_reg <= 1'b0;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg[0] <= s_data.key_part0[63:32];
            key_reg[1] <= s_data.key_part0[31:0];
            key_reg[2] <= s_data.key_part1[63:32];
            key_reg[3] <= s_data.key_part1[31:0];
            key_reg[4] <= s_data.key_part2[63:32];
            key_reg[5] <= s_data.key_part2[31:0];
            key_reg[6] <= s_data.key_part3[63:32];
            key_reg[7] <= s_data.key_part3[31:0];
        end
        if (advance) begin
            idx_out_reg  <= grp_reg;
            last_out_reg <= grp_reg == nr;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data.round_key_high = {upper_w[0], upper_w[1]};
    assign m_data.round_key_low  = {upper_w[2], upper_w[3]};
    assign m_data.round_index    = idx_out_reg;
    assign m_data.last_round     = last_out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/akx_checker.sv
`default_nettype none

module akx_checker
    import akx_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire akx_out_t m_data
);

    // stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one key at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second key taken during expansion");

    // keys still to come for this run, so no new key may enter
    a_no_accept_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_round |-> !s_ready)
        else $error("input ready before last round key");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.round_index != 4'd15)
        else $error("round index out of range");

endmodule

bind aes_key_expansion_unit akx_checker u_akx_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// File: test/aes_key_expansion_unit_tb.sv
module aes_key_expansion_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import akx_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int NUM_ROWS     = 20;

    typedef struct packed {
        logic [3:0]   key_len;
        logic [3:0]   rounds;
        akx_in_t      key;
        logic         typed;      // last round key typed in below
        logic [127:0] last_key;
    } key_row_t;

    // the unused key words of the short keys carry junk, they must be ignored
    localparam key_row_t KEY_TABLE [NUM_ROWS] = '{
        '{4'd4, 4'd10, {64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
                        64'h0123456789abcdef, 64'hfedcba9876543210},
          1'b1, 128'hd014f9a8c9ee2589_e13f0cc8b6630ca6},
        '{4'd6, 4'd12, {64'h8e73b0f7da0e6452, 64'hc810f32b809079e5,
                        64'h62f8ead2522c6b7b, 64'hffffffffffffffff},
          1'b1, 128'he98ba06f448c773c_8ecc720401002202},
        '{4'd8, 4'd14, {64'h603deb1015ca71be, 64'h2b73aef0857d7781,
                        64'h1f352c073b6108d7, 64'h2d9810a30914dff4},
          1'b1, 128'hfe4890d1e6188d0b_046df344706c631e},
        '{4'd4, 4'd10, {4{64'h0}}, 1'b0, 128'h0},
        '{4'd4, 4'd10, {4{64'hffffffffffffffff}}, 1'b0, 128'h0},
        '{4'd8, 4'd14, {4{64'h0}}, 1'b0, 128'h0},
        '{4'd8, 4'd14, {4{64'hffffffffffffffff}}, 1'b0, 128'h0},
        '{4'd0, 4'd10, {4{64'h5555aaaa5555aaaa}}, 1'b0, 128'h0},
        '{4'd3, 4'd1,  {4{64'haaaa5555aaaa5555}}, 1'b0, 128'h0},
        '{4'd5, 4'd10, {64'h0011223344556677, 64'h8899aabbccddeeff,
                        64'h0f1e2d3c4b5a6978, 64'h8796a5b4c3d2e1f0}, 1'b0, 128'h0},
        '{4'd7, 4'd13, {64'hf0e1d2c3b4a59687, 64'h78695a4b3c2d1e0f,
                        64'hffeeddccbbaa9988, 64'h7766554433221100}, 1'b0, 128'h0},
        '{4'd9, 4'd14, {64'h8000000000000001, 64'h0000000180000000,
                        64'h7fffffffffffffff, 64'hfffffffe00000000}, 1'b0, 128'h0},
        '{4'd15, 4'd15, {64'h1357924680acebdf, 64'h2468ace013579bdf,
                         64'hdeadbeefcafef00d, 64'h0badf00dfeedface}, 1'b0, 128'h0},
        '{4'd6, 4'd0,  {64'h3c3c3c3cc3c3c3c3, 64'h0f0f0f0ff0f0f0f0,
                        64'h0123456789abcdef, 64'h1111111111111111}, 1'b0, 128'h0},
        '{4'd4, 4'd15, {64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
                        64'h0, 64'h0}, 1'b0, 128'h0},
        '{4'd4, 4'd14, {4{64'hffffffffffffffff}}, 1'b0, 128'h0},
        '{4'd8, 4'd1,  {64'h603deb1015ca71be, 64'h2b73aef0857d7781,
                        64'h1f352c073b6108d7, 64'h2d9810a30914dff4}, 1'b0, 128'h0},
        '{4'd6, 4'd15, {4{64'hffffffffffffffff}}, 1'b0, 128'h0},
        '{4'd4, 4'd1,  {4{64'h0}}, 1'b0, 128'h0},
        '{4'd8, 4'd0,  {4{64'h0123456789abcdef}}, 1'b0, 128'h0}
    };

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     cfg_we    = 1'b0;
    logic     cfg_index = CFG_KEY_WORDS;
    logic [3:0] cfg_wdata = 4'd0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    akx_in_t  s_data    = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    akx_out_t m_data;

    // predictor state
    logic [3:0] key_len_cfg = 4'd4;
    logic [3:0] rounds_cfg  = 4'd10;
    logic [7:0] sbox_lut [256];
    akx_out_t   round_keys_due [$];
    akx_out_t   due_key;

    int mismatches  = 0;
    int cycle_count = 0;
    int holds_asked = 0;

    aes_key_expansion_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d round keys outstanding",
                     cycle_count, round_keys_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // S-box built from the GF(2^8) inverse and the affine map
    function automatic void build_sbox_lut();
        logic [7:0] inv, a, b, p;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++) begin
                a = 8'(x);
                b = 8'(y);
                p = 8'h00;
                for (int n = 0; n < 8; n++) begin
                    if (b[0])
                        p = p ^ a;
                    a = xtime(a);
                    b = b >> 1;
                end
                if (p == 8'h01)
                    inv = 8'(y);
            end
            sbox_lut[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
    endfunction

    function automatic word_t sbox_word(input word_t w);
        sbox_word = {sbox_lut[w[31:24]], sbox_lut[w[23:16]],
                     sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
    endfunction

    // expand one master key under the current settings, queue its round keys
    function automatic void expand_key_schedule(input akx_in_t key);
        word_t       sched [4*(MAX_ROUNDS+1)];
        logic [63:0] part;
        logic [7:0]  rcon;
        word_t       t;
        akx_out_t    rk;
        int          nk, nr, total;
        nk = int'(key_len_cfg);
        if (nk < 4)
            nk = 4;
        if (nk > MAX_KEY_WORDS)
            nk = MAX_KEY_WORDS;
        nr = int'(rounds_cfg);
        if (nr < 1)
            nr = 1;
        if (nr > MAX_ROUNDS)
            nr = MAX_ROUNDS;
        total = 4 * (nr + 1);
        rcon = 8'h01;
        for (int i = 0; i < nk; i++) begin
            case (i / 2)
                0: part = key.key_part0;
                1: part = key.key_part1;
                2: part = key.key_part2;
                default: part = key.key_part3;
            endcase
            sched[i] = (i % 2 == 1) ? part[31:0] : part[63:32];
        end
        for (int i = nk; i < total; i++) begin
            t = sched[i-1];
            if (i % nk == 0) begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = xtime(rcon);
            end else if (nk > 6 && i % nk == 4) begin
                t = sbox_word(t);
            end
            sched[i] = t ^ sched[i-nk];
        end
        for (int k = 0; k <= nr; k++) begin
            rk.round_key_high = {sched[4*k], sched[4*k+1]};
            rk.round_key_low  = {sched[4*k+2], sched[4*k+3]};
            rk.round_index    = 4'(k);
            rk.last_round     = (k == nr);
            round_keys_due = {round_keys_due, rk};
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (round_keys_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0d] unexpected round key %h_%h idx %0d last %0b",
                             cycle_count, m_data.round_key_high, m_data.round_key_low,
                             m_data.round_index, m_data.last_round);
            end else begin
                due_key = round_keys_due.pop_front();
                if (m_data.round_key_high !== due_key.round_key_high ||
                    m_data.round_key_low !== due_key.round_key_low ||
                    m_data.round_index !== due_key.round_index ||
                    m_data.last_round !== due_key.last_round) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0d] round key mismatch: exp %h_%h idx %0d last %0b, got %h_%h idx %0d last %0b",
                                 cycle_count,
                                 due_key.round_key_high, due_key.round_key_low,
                                 due_key.round_index, due_key.last_round,
                                 m_data.round_key_high, m_data.round_key_low,
                                 m_data.round_index, m_data.last_round);
                end
            end
        end
    end

    // result side: bursts, short stalls, the odd long one, and a forced hold-off
    initial begin
        int r;
        int holds_done;
        holds_done = 0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (holds_asked > holds_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 30)) @(posedge aclk);
                end else if (r < 90) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge aclk);
                end
            end
        end
    end

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (round_keys_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_config(input logic [3:0] key_len, input logic [3:0] rounds);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_KEY_WORDS;
        cfg_wdata <= key_len;
        @(posedge aclk);
        key_len_cfg = key_len;
        cfg_index <= CFG_ROUND_COUNT;
        cfg_wdata <= rounds;
        @(posedge aclk);
        rounds_cfg = rounds;
        cfg_we <= 1'b0;
    endtask

    // one key transaction; leaves s_valid high when no gap follows
    task automatic send_key(input akx_in_t key, input logic typed,
                            input logic [127:0] typed_last);
        akx_out_t last;
        int       r, gap;
        s_valid <= 1'b1;
        s_data  <= key;
        do
            @(posedge aclk);
        while (!s_ready);
        expand_key_schedule(key);
        if (typed) begin
            last = round_keys_due[round_keys_due.size()-1];
            {last.round_key_high, last.round_key_low} = typed_last;
            round_keys_due[round_keys_due.size()-1] = last;
        end
        r = $urandom_range(0, 99);
        gap = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin
        akx_in_t    key;
        logic [3:0] key_len, rounds;
        int         sent, phase_len;
        build_sbox_lut();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int row = 0; row < NUM_ROWS; row++) begin
            if (KEY_TABLE[row].key_len != key_len_cfg || KEY_TABLE[row].rounds != rounds_cfg)
                apply_config(KEY_TABLE[row].key_len, KEY_TABLE[row].rounds);
            send_key(KEY_TABLE[row].key, KEY_TABLE[row].typed, KEY_TABLE[row].last_key);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 6) begin
                key_len = 4'(4 + 2 * $urandom_range(0, 2));
                rounds  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                      : key_len + 4'd6;
            end else begin
                key_len = 4'($urandom_range(0, 15));
                rounds  = 4'($urandom_range(0, 15));
            end
            apply_config(key_len, rounds);
            phase_len = $urandom_range(8, 40);
            for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
                key = {$urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom};
                for (int w = 0; w < 8; w++)
                    if ($urandom_range(0, 9) == 0)
                        key[w*32 +: 32] = $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
                // stall the result side while keys keep coming
                if (sent == 100)
                    holds_asked++;
                if (sent == 250)
                    wait_drained();
                send_key(key, 1'b0, '0);
                sent++;
            end
        end

        wait_drained();
        if (mismatches == 0 && round_keys_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/akx_pkg.sv
hw/rtl/akx_cell.sv
hw/rtl/aes_key_expansion_unit.sv
hw/rtl/akx_checker.sv
test/aes_key_expansion_unit_tb.sv
